// ===== sv/pmfb_pkg.sv =====
// Package for the paged monochrome framebuffer engine.
// Holds payload types, opcodes, controller states and control/status bundles.
// No dependencies.
`default_nettype none

package pmfb_pkg;

	// Default display geometry and rows per page
	localparam int DISPLAY_WIDTH_DEF  = 128;
	localparam int DISPLAY_HEIGHT_DEF = 64;
	localparam int PAGE_ROWS          = 8;

	// Command opcodes; unused codes fall to default arms
	typedef enum logic [2:0] {
		OP_CLEAR     = 3'd0,
		OP_SET       = 3'd1,
		OP_SET_EMIT  = 3'd2,
		OP_GET       = 3'd3,
		OP_FILL      = 3'd4,
		OP_EMIT_NEXT = 3'd5
	} op_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MODIFY,
		ST_FILL_RD,
		ST_FILL_WR
	} state_t;

	// Command beat
	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] rect_width;
		logic [7:0] rect_height;
	} cmd_item_t;

	// Response beat
	typedef struct packed {
		logic       result_kind;
		logic       pixel_on;
		logic [7:0] data_byte;
		logic [2:0] page_index;
		logic [6:0] column_index;
		logic       end_of_frame;
	} rsp_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take;
		logic clr_reset;
		logic clr_write;
		logic pix_write;
		logic out_load;
		logic fill_read;
		logic fill_write;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_done;
		logic fill_empty;
		logic fill_last;
		logic out_free;
		logic on_disp;
		op_t  op;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== sv/paged_mono_framebuffer_engine_top.sv =====
// Top level of the paged monochrome framebuffer engine.
// Joins the controller (pmfb_ctrl) and the datapath (pmfb_datapath); uses pmfb_pkg.
//
//   channel | signals                    | beat moves
//   --------+----------------------------+----------------------------------
//   cmd     | cmd_valid, cmd_stall, cmd  | one command (opcode, x, y, w, h)
//   rsp     | rsp_valid, rsp_stall, rsp  | one pixel answer or display byte
//
// Set, set-and-emit, get and emit-next each make one read and then one
// write/answer access on the single-port page store.
// Fill reads and then writes back each touched byte in turn; an empty rectangle writes nothing.
// Clear writes zero to all 2^(page bits + column bits) store bytes, 1024 at 128x64; a clearing
// sweep of all of them runs after reset, with cmd_stall high throughout.
// A stalled response holds the block in its answer cycle until taken.
`default_nettype none

module paged_mono_framebuffer_engine_top #(
	parameter int DISPLAY_WIDTH  = pmfb_pkg::DISPLAY_WIDTH_DEF,
	parameter int DISPLAY_HEIGHT = pmfb_pkg::DISPLAY_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  pmfb_pkg::cmd_item_t  cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output pmfb_pkg::rsp_item_t  rsp
);

	pmfb_pkg::dp_cmd_t    ctl;
	pmfb_pkg::dp_status_t status;

	pmfb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_opcode (cmd.opcode),
		.status     (status),
		.ctl        (ctl)
	);

	pmfb_datapath #(
		.DISPLAY_WIDTH  (DISPLAY_WIDTH),
		.DISPLAY_HEIGHT (DISPLAY_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== sv/pmfb_ctrl.sv =====
// Controller state machine for the paged monochrome framebuffer engine.
// Sequences clear sweeps, pixel read-modify-write and rectangle fills.
// Depends on pmfb_pkg.
`default_nettype none

module pmfb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  logic [2:0]            cmd_opcode,
	input  pmfb_pkg::dp_status_t  status,
	output pmfb_pkg::dp_cmd_t     ctl
);

	pmfb_pkg::state_t state_q;
	pmfb_pkg::state_t state_d;
	pmfb_pkg::op_t    in_op;
	logic             need_result;
	logic             need_write;

	assign in_op = pmfb_pkg::op_t'(cmd_opcode);

	// Decide what the held command still owes
	always_comb begin
		need_result = 1'b0;
		need_write  = 1'b0;
		case (status.op)
			pmfb_pkg::OP_SET: begin
				need_write = status.on_disp;
			end
			pmfb_pkg::OP_SET_EMIT: begin
				need_write  = status.on_disp;
				need_result = status.on_disp;
			end
			pmfb_pkg::OP_GET: begin
				need_result = 1'b1;
			end
			pmfb_pkg::OP_EMIT_NEXT: begin
				need_result = 1'b1;
			end
			default: begin
				need_result = 1'b0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pmfb_pkg::ST_CLEAR: begin
				if (status.clr_done) state_d = pmfb_pkg::ST_IDLE;
			end
			pmfb_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					case (in_op)
						pmfb_pkg::OP_CLEAR:     state_d = pmfb_pkg::ST_CLEAR;
						pmfb_pkg::OP_SET,
						pmfb_pkg::OP_SET_EMIT,
						pmfb_pkg::OP_GET,
						pmfb_pkg::OP_EMIT_NEXT: state_d = pmfb_pkg::ST_MODIFY;
						pmfb_pkg::OP_FILL:      state_d = pmfb_pkg::ST_FILL_RD;
						default:                state_d = pmfb_pkg::ST_IDLE;
					endcase
				end
			end
			pmfb_pkg::ST_MODIFY: begin
				if (!need_result || status.out_free) state_d = pmfb_pkg::ST_IDLE;
			end
			pmfb_pkg::ST_FILL_RD: begin
				if (status.fill_empty) state_d = pmfb_pkg::ST_IDLE;
				else state_d = pmfb_pkg::ST_FILL_WR;
			end
			pmfb_pkg::ST_FILL_WR: begin
				if (status.fill_last) state_d = pmfb_pkg::ST_IDLE;
				else state_d = pmfb_pkg::ST_FILL_RD;
			end
			default: begin
				state_d = pmfb_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs per state
	always_comb begin
		ctl       = '0;
		cmd_stall = 1'b1;
		case (state_q)
			pmfb_pkg::ST_CLEAR: begin
				ctl.clr_write = 1'b1;
			end
			pmfb_pkg::ST_IDLE: begin
				cmd_stall     = 1'b0;
				ctl.take      = cmd_valid;
				ctl.clr_reset = cmd_valid && (in_op == pmfb_pkg::OP_CLEAR);
			end
			pmfb_pkg::ST_MODIFY: begin
				// hold until the response register can take the beat
				if (!need_result || status.out_free) begin
					ctl.pix_write = need_write;
					ctl.out_load  = need_result;
				end
			end
			pmfb_pkg::ST_FILL_RD: begin
				ctl.fill_read = !status.fill_empty;
			end
			pmfb_pkg::ST_FILL_WR: begin
				ctl.fill_write = 1'b1;
			end
			default: begin
				cmd_stall = 1'b1;
			end
		endcase
	end

	// State register; reset starts with a clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmfb_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/pmfb_datapath.sv =====
// Datapath of the paged monochrome framebuffer engine: single-port page store,
// scan cursor, clear counter, fill walker and response register.
// Depends on pmfb_pkg.
`default_nettype none

module pmfb_datapath #(
	parameter int DISPLAY_WIDTH  = pmfb_pkg::DISPLAY_WIDTH_DEF,
	parameter int DISPLAY_HEIGHT = pmfb_pkg::DISPLAY_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pmfb_pkg::cmd_item_t   cmd,
	input  pmfb_pkg::dp_cmd_t     ctl,
	output pmfb_pkg::dp_status_t  status,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output pmfb_pkg::rsp_item_t   rsp
);

	localparam int PAGE_COUNT = (DISPLAY_HEIGHT + pmfb_pkg::PAGE_ROWS - 1) / pmfb_pkg::PAGE_ROWS;
	localparam int COL_W      = $clog2(DISPLAY_WIDTH);
	localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int ADDR_W     = PAGE_W + COL_W;
	localparam int DEPTH      = 1 << ADDR_W;

	// Page store: address is {page, column}
	logic [7:0]        store_q [DEPTH];
	logic [7:0]        rd_q;
	logic [ADDR_W-1:0] mem_addr;
	logic [7:0]        mem_wdata;
	logic              mem_we;
	logic              mem_re;

	// Held command
	pmfb_pkg::op_t     op_q;
	logic              on_disp_q;
	logic [2:0]        bit_q;
	logic [ADDR_W-1:0] addr_q;
	logic              eof_q;

	// Scan cursor and clear counter
	logic [PAGE_W-1:0] cur_page_q;
	logic [COL_W-1:0]  cur_col_q;
	logic              cur_last;
	logic [ADDR_W-1:0] clr_cnt_q;

	// Fill walker
	logic [COL_W-1:0]  fill_col_q;
	logic [COL_W-1:0]  fill_col_first_q;
	logic [COL_W-1:0]  fill_col_last_q;
	logic [PAGE_W-1:0] fill_page_q;
	logic [PAGE_W-1:0] fill_page_first_q;
	logic [PAGE_W-1:0] fill_page_last_q;
	logic [2:0]        fill_lo_q;
	logic [2:0]        fill_hi_q;
	logic              fill_empty_q;
	logic [2:0]        mask_lo;
	logic [2:0]        mask_hi;
	logic [7:0]        fill_mask;

	// Incoming command decode
	pmfb_pkg::op_t     in_op;
	logic              in_on_disp;
	logic [ADDR_W-1:0] pix_addr;
	logic [ADDR_W-1:0] take_addr;
	logic [8:0]        xe_sum;
	logic [8:0]        ye_sum;
	logic [8:0]        xe;
	logic [8:0]        ye;
	logic [8:0]        xe_m1;
	logic [8:0]        ye_m1;
	logic              in_fill_empty;

	// Response register
	logic                rsp_valid_q;
	pmfb_pkg::rsp_item_t rsp_q;
	pmfb_pkg::rsp_item_t rsp_d;

	// Decode the command beat
	always_comb begin
		in_op      = pmfb_pkg::op_t'(cmd.opcode);
		in_on_disp = ({1'b0, cmd.pos_x} < 9'(DISPLAY_WIDTH)) &&
		             ({1'b0, cmd.pos_y} < 9'(DISPLAY_HEIGHT));
		pix_addr   = {PAGE_W'(cmd.pos_y[7:3]), cmd.pos_x[COL_W-1:0]};
		take_addr  = (in_op == pmfb_pkg::OP_EMIT_NEXT) ? {cur_page_q, cur_col_q} : pix_addr;
		// clip rectangle edges to the display, no coordinate wrap
		xe_sum = {1'b0, cmd.pos_x} + {1'b0, cmd.rect_width};
		ye_sum = {1'b0, cmd.pos_y} + {1'b0, cmd.rect_height};
		xe     = (xe_sum > 9'(DISPLAY_WIDTH)) ? 9'(DISPLAY_WIDTH) : xe_sum;
		ye     = (ye_sum > 9'(DISPLAY_HEIGHT)) ? 9'(DISPLAY_HEIGHT) : ye_sum;
		xe_m1  = xe - 9'd1;
		ye_m1  = ye - 9'd1;
		in_fill_empty = ({1'b0, cmd.pos_x} >= xe) || ({1'b0, cmd.pos_y} >= ye);
	end

	assign cur_last = (cur_page_q == PAGE_W'(PAGE_COUNT - 1)) &&
	                  (cur_col_q == COL_W'(DISPLAY_WIDTH - 1));

	// Latch the command on the accepted beat
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			op_q              <= in_op;
			on_disp_q         <= in_on_disp;
			bit_q             <= cmd.pos_y[2:0];
			addr_q            <= take_addr;
			eof_q             <= (in_op == pmfb_pkg::OP_EMIT_NEXT) && cur_last;
			fill_empty_q      <= in_fill_empty;
			fill_col_q        <= cmd.pos_x[COL_W-1:0];
			fill_col_first_q  <= cmd.pos_x[COL_W-1:0];
			fill_col_last_q   <= xe_m1[COL_W-1:0];
			fill_page_q       <= PAGE_W'(cmd.pos_y[7:3]);
			fill_page_first_q <= PAGE_W'(cmd.pos_y[7:3]);
			fill_page_last_q  <= PAGE_W'(ye_m1[7:3]);
			fill_lo_q         <= cmd.pos_y[2:0];
			fill_hi_q         <= ye_m1[2:0];
		end else if (ctl.fill_write) begin
			// advance column first, then page
			if (fill_col_q == fill_col_last_q) begin
				fill_col_q  <= fill_col_first_q;
				fill_page_q <= fill_page_q + PAGE_W'(1);
			end else begin
				fill_col_q <= fill_col_q + COL_W'(1);
			end
		end
	end

	// Row mask of the current fill page
	always_comb begin
		mask_lo   = (fill_page_q == fill_page_first_q) ? fill_lo_q : 3'd0;
		mask_hi   = (fill_page_q == fill_page_last_q) ? fill_hi_q : 3'd7;
		fill_mask = (8'hFF << mask_lo) & (8'hFF >> (3'd7 - mask_hi));
	end

	// Scan cursor and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_page_q <= '0;
			cur_col_q  <= '0;
			clr_cnt_q  <= '0;
		end else begin
			if (ctl.take && (in_op == pmfb_pkg::OP_EMIT_NEXT)) begin
				if (cur_last) begin
					cur_page_q <= '0;
					cur_col_q  <= '0;
				end else if (cur_col_q == COL_W'(DISPLAY_WIDTH - 1)) begin
					cur_page_q <= cur_page_q + PAGE_W'(1);
					cur_col_q  <= '0;
				end else begin
					cur_col_q <= cur_col_q + COL_W'(1);
				end
			end
			if (ctl.clr_reset) begin
				clr_cnt_q <= '0;
			end else if (ctl.clr_write) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end
		end
	end

	// Store port select
	always_comb begin
		mem_we    = ctl.clr_write | ctl.pix_write | ctl.fill_write;
		mem_re    = ctl.take | ctl.fill_read;
		mem_addr  = {fill_page_q, fill_col_q};
		mem_wdata = rd_q | fill_mask;
		if (ctl.take) begin
			mem_addr = take_addr;
		end else if (ctl.clr_write) begin
			mem_addr  = clr_cnt_q;
			mem_wdata = 8'h00;
		end else if (ctl.pix_write) begin
			mem_addr  = addr_q;
			mem_wdata = rd_q | (8'h01 << bit_q);
		end
	end

	// Single-port store with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= store_q[mem_addr];
		end
	end

	// Build the response beat
	always_comb begin
		rsp_d = '0;
		case (op_q)
			pmfb_pkg::OP_GET: begin
				rsp_d.result_kind = 1'b0;
				rsp_d.pixel_on    = on_disp_q & rd_q[bit_q];
			end
			pmfb_pkg::OP_SET_EMIT: begin
				rsp_d.result_kind  = 1'b1;
				rsp_d.data_byte    = rd_q | (8'h01 << bit_q);
				rsp_d.page_index   = 3'(addr_q[ADDR_W-1:COL_W]);
				rsp_d.column_index = 7'(addr_q[COL_W-1:0]);
			end
			pmfb_pkg::OP_EMIT_NEXT: begin
				rsp_d.result_kind  = 1'b1;
				rsp_d.data_byte    = rd_q;
				rsp_d.page_index   = 3'(addr_q[ADDR_W-1:COL_W]);
				rsp_d.column_index = 7'(addr_q[COL_W-1:0]);
				rsp_d.end_of_frame = eof_q;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	// Response register: drop the beat once taken, load when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status back to the controller
	always_comb begin
		status.clr_done   = &clr_cnt_q;
		status.fill_empty = fill_empty_q;
		status.fill_last  = (fill_col_q == fill_col_last_q) &&
		                    (fill_page_q == fill_page_last_q);
		status.out_free   = !rsp_valid_q || !rsp_stall;
		status.on_disp    = on_disp_q;
		status.op         = op_q;
	end

endmodule

`default_nettype wire

// ===== test/paged_mono_framebuffer_engine_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for paged_mono_framebuffer_engine_top: a directed command table, mostly with its
// expected answers written in the table, then random draw and refresh bursts checked against a
// behavioral page-store predictor. Depends on pmfb_pkg and the engine RTL.

module paged_mono_framebuffer_engine_top_tb;

	localparam int DISP_W       = pmfb_pkg::DISPLAY_WIDTH_DEF;
	localparam int DISP_H       = pmfb_pkg::DISPLAY_HEIGHT_DEF;
	localparam int ROWS         = pmfb_pkg::PAGE_ROWS;
	localparam int DISP_PAGES   = (DISP_H + ROWS - 1) / ROWS;
	localparam int FRAME_BYTES  = DISP_W * DISP_PAGES;
	localparam int RANDOM_ITEMS = 1450;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int TAIL_CYCLES  = 2200;

	// Opcodes the engine ignores
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	// Answer kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_BYTE  = 1'b1;

	// One row of the directed table; want is used only when typed is set
	typedef struct {
		pmfb_pkg::cmd_item_t cmd;
		bit                  typed;
		bit                  answers;
		pmfb_pkg::rsp_item_t want;
	} probe_row_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	pmfb_pkg::cmd_item_t cmd       = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	pmfb_pkg::rsp_item_t rsp;

	// Predictor state: one byte per column and page, plus the refresh cursor
	logic [7:0]  page_bytes [DISP_W][DISP_PAGES];
	int unsigned scan_pos;

	pmfb_pkg::rsp_item_t pending_answers[$];
	probe_row_t          probe_rows[$];

	int error_count     = 0;
	int commands_sent   = 0;
	int answers_checked = 0;
	int frames_wrapped  = 0;
	int send_idle_pct   = 31;
	int recv_idle_pct   = 58;
	int holds_asked     = 0;
	int holds_served    = 0;
	int hold_left       = 0;

	paged_mono_framebuffer_engine_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic void wipe_store();
		foreach (page_bytes[i, j])
			page_bytes[i][j] = '0;
	endfunction

	function automatic bit visible(input int unsigned x, input int unsigned y);
		return x < DISP_W && y < DISP_H;
	endfunction

	// Pixel writes only ever turn a pixel on
	function automatic void light_pixel(input int unsigned x, input int unsigned y);
		if (visible(x, y))
			page_bytes[x][y / ROWS][y % ROWS] = 1'b1;
	endfunction

	// Advance the page store for one command and work out its answer, if any
	function automatic void model_command(input pmfb_pkg::cmd_item_t c, output bit has_rsp,
			output pmfb_pkg::rsp_item_t r);
		int unsigned x, y, x_end, y_end, cx, cy;
		x       = 32'(c.pos_x);
		y       = 32'(c.pos_y);
		has_rsp = 1'b0;
		r       = '0;
		case (c.opcode)
		pmfb_pkg::OP_CLEAR: wipe_store();
		pmfb_pkg::OP_SET: light_pixel(x, y);
		pmfb_pkg::OP_SET_EMIT: begin
			if (visible(x, y)) begin
				light_pixel(x, y);
				has_rsp        = 1'b1;
				r.result_kind  = KIND_BYTE;
				r.data_byte    = page_bytes[x][y / ROWS];
				r.page_index   = 3'(y / ROWS);
				r.column_index = 7'(x);
			end
		end
		pmfb_pkg::OP_GET: begin
			has_rsp       = 1'b1;
			r.result_kind = KIND_PIXEL;
			if (visible(x, y))
				r.pixel_on = page_bytes[x][y / ROWS][y % ROWS];
		end
		pmfb_pkg::OP_FILL: begin
			// no coordinate wrap: clip the far edges to the panel
			x_end = x + 32'(c.rect_width);
			y_end = y + 32'(c.rect_height);
			if (x_end > DISP_W)
				x_end = DISP_W;
			if (y_end > DISP_H)
				y_end = DISP_H;
			for (cy = y; cy < y_end; cy++)
				for (cx = x; cx < x_end; cx++)
					light_pixel(cx, cy);
		end
		pmfb_pkg::OP_EMIT_NEXT: begin
			if (scan_pos >= FRAME_BYTES)
				scan_pos = 0;
			has_rsp        = 1'b1;
			r.result_kind  = KIND_BYTE;
			r.data_byte    = page_bytes[scan_pos % DISP_W][scan_pos / DISP_W];
			r.page_index   = 3'(scan_pos / DISP_W);
			r.column_index = 7'(scan_pos % DISP_W);
			r.end_of_frame = (scan_pos + 1 == FRAME_BYTES);
			if (r.end_of_frame) begin
				scan_pos = 0;
				frames_wrapped++;
			end else begin
				scan_pos++;
			end
		end
		default: ;
		endcase
	endfunction

	function automatic pmfb_pkg::cmd_item_t mk_cmd(input logic [2:0] op, input int x,
			input int y, input int w, input int h);
		pmfb_pkg::cmd_item_t c;
		c.opcode      = op;
		c.pos_x       = 8'(x);
		c.pos_y       = 8'(y);
		c.rect_width  = 8'(w);
		c.rect_height = 8'(h);
		return c;
	endfunction

	function automatic pmfb_pkg::rsp_item_t mk_rsp(input logic kind, input int on,
			input int data_v, input int page, input int col, input int eof);
		pmfb_pkg::rsp_item_t r;
		r.result_kind  = kind;
		r.pixel_on     = 1'(on);
		r.data_byte    = 8'(data_v);
		r.page_index   = 3'(page);
		r.column_index = 7'(col);
		r.end_of_frame = 1'(eof);
		return r;
	endfunction

	// Random drawing command; unused fields carry noise
	function automatic pmfb_pkg::cmd_item_t random_draw();
		pmfb_pkg::cmd_item_t c;
		int unsigned         pick;
		c = mk_cmd(pmfb_pkg::OP_SET, $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 2)
			c.opcode = pmfb_pkg::OP_CLEAR;
		else if (pick < 27)
			c.opcode = pmfb_pkg::OP_SET;
		else if (pick < 52)
			c.opcode = pmfb_pkg::OP_SET_EMIT;
		else if (pick < 77)
			c.opcode = pmfb_pkg::OP_GET;
		else if (pick < 94)
			c.opcode = pmfb_pkg::OP_FILL;
		else if (pick < 97)
			c.opcode = OP_SPARE_6;
		else
			c.opcode = OP_SPARE_7;
		// keep most coordinates on the panel
		if ($urandom_range(7) != 0) begin
			c.pos_x = 8'($urandom_range(DISP_W - 1));
			c.pos_y = 8'($urandom_range(DISP_H - 1));
		end
		// mostly small rectangles; a rare one spans the whole field range
		if (c.opcode == pmfb_pkg::OP_FILL && $urandom_range(15) != 0) begin
			c.rect_width  = 8'($urandom_range(12));
			c.rect_height = 8'($urandom_range(12));
		end
		return c;
	endfunction

	// Offer one command beat, hold it until taken, then log its answer
	task automatic drive_command(input pmfb_pkg::cmd_item_t c, input bit typed,
			input bit answers, input pmfb_pkg::rsp_item_t want);
		bit                  has_rsp;
		pmfb_pkg::rsp_item_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		model_command(c, has_rsp, predicted);
		if (typed ? answers : has_rsp)
			pending_answers.push_back(typed ? want : predicted);
		commands_sent++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got_v,
			input logic [7:0] want_v);
		if (got_v !== want_v)
			report_mismatch($sformatf("%s: got %0h, expected %0h", name, got_v, want_v));
	endtask

	task automatic check_answer(input pmfb_pkg::rsp_item_t got);
		pmfb_pkg::rsp_item_t want;
		if (pending_answers.size() == 0) begin
			report_mismatch($sformatf("answer beat %h with nothing outstanding", got));
			return;
		end
		want = pending_answers.pop_front();
		answers_checked++;
		check_field("result_kind", 8'(got.result_kind), 8'(want.result_kind));
		check_field("pixel_on", 8'(got.pixel_on), 8'(want.pixel_on));
		check_field("data_byte", got.data_byte, want.data_byte);
		check_field("page_index", 8'(got.page_index), 8'(want.page_index));
		check_field("column_index", 8'(got.column_index), 8'(want.column_index));
		check_field("end_of_frame", 8'(got.end_of_frame), 8'(want.end_of_frame));
	endtask

	// Answer side: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left    <= HOLD_CYCLES;
			rsp_stall    <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Check every answer beat taken
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			check_answer(rsp);
	end

	initial begin
		pmfb_pkg::cmd_item_t c;
		int unsigned         rand_items;
		int                  waited;
		rand_items = 0;
		waited     = 0;
		wipe_store();
		scan_pos = 0;

		// Directed table: panel corners, off-panel coordinates, clipped and empty fills
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_GET, 0, 0, 0, 0), 1'b1, 1'b1,
			mk_rsp(KIND_PIXEL, 0, 'h00, 0, 0, 0)});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_EMIT_NEXT, 0, 0, 0, 0), 1'b1, 1'b1,
			mk_rsp(KIND_BYTE, 0, 'h00, 0, 0, 0)});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_SET_EMIT, 0, 0, 0, 0), 1'b1, 1'b1,
			mk_rsp(KIND_BYTE, 0, 'h01, 0, 0, 0)});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_SET_EMIT, 127, 63, 255, 255), 1'b1, 1'b1,
			mk_rsp(KIND_BYTE, 0, 'h80, 7, 127, 0)});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_SET_EMIT, 128, 0, 0, 0), 1'b1, 1'b0, '0});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_SET_EMIT, 0, 64, 0, 0), 1'b1, 1'b0, '0});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_SET_EMIT, 255, 255, 0, 0), 1'b1, 1'b0,
			'0});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_GET, 127, 63, 0, 0), 1'b1, 1'b1,
			mk_rsp(KIND_PIXEL, 1, 'h00, 0, 0, 0)});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_GET, 255, 255, 255, 255), 1'b1, 1'b1,
			mk_rsp(KIND_PIXEL, 0, 'h00, 0, 0, 0)});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_SET, 255, 255, 0, 0), 1'b1, 1'b0, '0});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_SET, 5, 9, 0, 0), 1'b1, 1'b0, '0});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_GET, 5, 9, 0, 0), 1'b1, 1'b1,
			mk_rsp(KIND_PIXEL, 1, 'h00, 0, 0, 0)});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_FILL, 120, 60, 255, 255), 1'b1, 1'b0, '0});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_FILL, 10, 10, 0, 20), 1'b1, 1'b0, '0});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_FILL, 10, 10, 20, 0), 1'b1, 1'b0, '0});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_FILL, 250, 250, 255, 255), 1'b1, 1'b0,
			'0});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_GET, 124, 62, 0, 0), 1'b0, 1'b0, '0});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_GET, 15, 15, 0, 0), 1'b1, 1'b1,
			mk_rsp(KIND_PIXEL, 0, 'h00, 0, 0, 0)});
		probe_rows.push_back('{mk_cmd(OP_SPARE_6, 255, 255, 255, 255), 1'b1, 1'b0, '0});
		probe_rows.push_back('{mk_cmd(OP_SPARE_7, 0, 0, 0, 0), 1'b1, 1'b0, '0});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_FILL, 0, 0, 255, 255), 1'b1, 1'b0, '0});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_SET_EMIT, 64, 32, 0, 0), 1'b1, 1'b1,
			mk_rsp(KIND_BYTE, 0, 'hFF, 4, 64, 0)});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_CLEAR, 0, 0, 0, 0), 1'b1, 1'b0, '0});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_GET, 64, 32, 0, 0), 1'b1, 1'b1,
			mk_rsp(KIND_PIXEL, 0, 'h00, 0, 0, 0)});
		probe_rows.push_back('{mk_cmd(pmfb_pkg::OP_EMIT_NEXT, 255, 255, 255, 255), 1'b0, 1'b0,
			'0});

		// Hold reset, then release it; the engine clears its store before taking beats
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (probe_rows[i])
			drive_command(probe_rows[i].cmd, probe_rows[i].typed, probe_rows[i].answers,
				probe_rows[i].want);

		// Random part: drawing bursts mixed with refresh bursts, run on past one frame wrap
		while (rand_items < RANDOM_ITEMS || frames_wrapped == 0) begin
			if (rand_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 31;
				recv_idle_pct = 58;
			end else if (rand_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 58;
				recv_idle_pct = 31;
			end else begin
				// entering the no-idle stretch: ask for one long answer hold-off
				if (send_idle_pct != 0)
					holds_asked <= holds_asked + 1;
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			repeat ($urandom_range(1, 8)) begin
				c = random_draw();
				drive_command(c, 1'b0, 1'b0, '0);
				if (c.opcode <= pmfb_pkg::OP_EMIT_NEXT)
					rand_items++;
			end
			repeat ($urandom_range(1, 24)) begin
				c        = random_draw();
				c.opcode = pmfb_pkg::OP_EMIT_NEXT;
				drive_command(c, 1'b0, 1'b0, '0);
				rand_items++;
			end
		end
		cmd_valid <= 1'b0;

		// Drain outstanding answers, then let any trailing fill or clear finish
		while (pending_answers.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_answers.size() != 0)
			report_mismatch($sformatf("%0d answers never arrived", pending_answers.size()));

		$display("Drove %0d commands (%0d from the directed table) and checked %0d answers.",
			commands_sent, probe_rows.size(), answers_checked);
		$display("Refresh scan wrapped %0d time(s); %0d mismatches found.", frames_wrapped,
			error_count);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("Run timed out waiting on the engine.");
		$display("Test completed with failures");
		$finish;
	end

endmodule
